/* rtl/grid_dfs_path_solver_assert.svh */
// Assertion macros used by the checker file of the grid path solver.
// Each macro builds one concurrent assertion clocked by clk and held off during rst.
`ifndef GRID_DFS_PATH_SOLVER_ASSERT_SVH
`define GRID_DFS_PATH_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gdfs_pkg.sv */
// Shared constants, types and helper functions for the grid path solver.
// No dependencies; the register file, core, top level and checker import this package.
package gdfs_pkg;

  // Grid storage size.
  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int STK_W    = ROW_W + COL_W;
  localparam int DEPTH_W  = $clog2(CELLS + 1);

  // Width of a clamped size, and of the signed neighbor arithmetic.
  localparam int SZ_W = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
  localparam int SW   = SZ_W + 2;

  // Port field widths.
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 4;
  localparam int CODE_W  = 3;
  localparam int LEN_W   = 9;
  localparam int CNT_W   = 5;
  localparam int ORDER_W = 8;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Actions.
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SOLVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  // Cell codes; arrows run from CODE_ARROW (east) upward by direction.
  localparam logic [CODE_W-1:0] CODE_OPEN  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_WALL  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_DEAD  = 3'd2;
  localparam logic [CODE_W-1:0] CODE_ARROW = 3'd3;

  // Directions.
  localparam logic [1:0] DIR_EAST  = 2'd0;
  localparam logic [1:0] DIR_SOUTH = 2'd1;
  localparam logic [1:0] DIR_WEST  = 2'd2;
  localparam logic [1:0] DIR_NORTH = 2'd3;

  // Register indexes and reset values.
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_ORDER = 2'd2;
  localparam logic [CNT_W-1:0]   ROWS_RST  = 5'd10;
  localparam logic [CNT_W-1:0]   COLS_RST  = 5'd10;
  localparam logic [ORDER_W-1:0] ORDER_RST = 8'd228;

  // Clamped search setup handed from the register file to the core.
  typedef struct packed {
    logic [SZ_W-1:0]    rows;
    logic [SZ_W-1:0]    cols;
    logic [ORDER_W-1:0] order;
  } cfg_t;

  // Finished result handed from the core to the output register.
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic              found;
    logic [LEN_W-1:0]  len;
  } res_t;

  // Row step of a direction.
  function automatic logic signed [SW-1:0] step_row(input logic [1:0] dir);
    logic signed [SW-1:0] s;
    unique case (dir)
      DIR_SOUTH: s = 1;
      DIR_NORTH: s = -1;
      DIR_EAST:  s = 0;
      DIR_WEST:  s = 0;
    endcase
    return s;
  endfunction

  // Column step of a direction.
  function automatic logic signed [SW-1:0] step_col(input logic [1:0] dir);
    logic signed [SW-1:0] s;
    unique case (dir)
      DIR_EAST:  s = 1;
      DIR_WEST:  s = -1;
      DIR_SOUTH: s = 0;
      DIR_NORTH: s = 0;
    endcase
    return s;
  endfunction

  // Linear grid address of a cell.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_COLS + int'(c));
  endfunction

endpackage

/* rtl/gdfs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies; used for the grid store and the search stack.
module gdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; the read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/gdfs_cfg.sv */
// Configuration register file of the grid path solver behind an APB-style port.
// Depends on gdfs_pkg; hands the clamped grid size and direction order to the core.
module gdfs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gdfs_pkg::PADDR_W-1:0]  paddr,
  input  logic [gdfs_pkg::PDATA_W-1:0]  pwdata,
  output logic [gdfs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output gdfs_pkg::cfg_t                cfg
);
  import gdfs_pkg::*;

  logic [CNT_W-1:0]   row_count;
  logic [CNT_W-1:0]   col_count;
  logic [ORDER_W-1:0] dir_order;
  logic [1:0]         reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  // Register writes during the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROWS_RST;
      col_count <= COLS_RST;
      dir_order <= ORDER_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ROWS:  row_count <= pwdata[CNT_W-1:0];
        REG_COLS:  col_count <= pwdata[CNT_W-1:0];
        REG_ORDER: dir_order <= pwdata[ORDER_W-1:0];
        default:   ;
      endcase
    end
  end

  // Read-back of the stored values.
  always_comb begin
    unique case (reg_idx)
      REG_ROWS:  prdata = PDATA_W'(row_count);
      REG_COLS:  prdata = PDATA_W'(col_count);
      REG_ORDER: prdata = PDATA_W'(dir_order);
      default:   prdata = '0;
    endcase
  end

  // Sizes are saturated into the range the grid store supports.
  always_comb begin
    if (row_count < 3) begin
      cfg.rows = SZ_W'(3);
    end else if (row_count > MAX_ROWS) begin
      cfg.rows = SZ_W'(MAX_ROWS);
    end else begin
      cfg.rows = SZ_W'(row_count);
    end
    if (col_count < 3) begin
      cfg.cols = SZ_W'(3);
    end else if (col_count > MAX_COLS) begin
      cfg.cols = SZ_W'(MAX_COLS);
    end else begin
      cfg.cols = SZ_W'(col_count);
    end
    cfg.order = dir_order;
  end

endmodule

/* rtl/gdfs_core.sv */
// Search sequencer of the grid path solver: grid store, path stack and the control
// that reads, marks and writes them back. Depends on gdfs_pkg and gdfs_ram.
module gdfs_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gdfs_pkg::ACT_W-1:0]  action,
  input  logic [gdfs_pkg::IDX_W-1:0]  row,
  input  logic [gdfs_pkg::IDX_W-1:0]  col,
  input  logic                        cell_in,
  input  gdfs_pkg::cfg_t              cfg,
  input  logic                        res_take,
  output gdfs_pkg::res_t              res
);
  import gdfs_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_TOP   = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_POP   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic signed [SW-1:0] ONE_S = 1;
  localparam logic signed [SW-1:0] TWO_S = 2;
  localparam logic signed [SW-1:0] ZERO_S = 0;

  // Control and payload registers.
  logic [2:0]         state, state_next;
  logic [ADDR_W-1:0]  clr_addr, clr_addr_next;
  logic [DEPTH_W-1:0] depth, depth_next;
  logic [ROW_W-1:0]   top_r, top_r_next, nb_r, nb_r_next;
  logic [COL_W-1:0]   top_c, top_c_next, nb_c, nb_c_next;
  logic [1:0]         dir_i, dir_i_next;
  logic               rd_ok, rd_ok_next;
  logic [CODE_W-1:0]  res_cell, res_cell_next;
  logic               res_found, res_found_next;
  logic [LEN_W-1:0]   res_len, res_len_next;

  // Memory ports.
  logic               g_we;
  logic [ADDR_W-1:0]  g_waddr, g_raddr;
  logic [CODE_W-1:0]  g_wdata, g_rdata;
  logic               s_we;
  logic [ADDR_W-1:0]  s_waddr, s_raddr;
  logic [STK_W-1:0]   s_wdata, s_rdata;

  // Neighbor arithmetic.
  logic [1:0]           cur_dir;
  logic signed [SW-1:0] tr_s, tc_s, rows_s, cols_s, nr, nc;
  logic                 nb_ok, goal, dead, in_store;
  logic [ADDR_W-1:0]    in_addr;

  gdfs_ram #(.WIDTH(CODE_W), .DEPTH(CELLS)) u_grid (
    .clk  (clk),
    .we   (g_we),
    .waddr(g_waddr),
    .wdata(g_wdata),
    .raddr(g_raddr),
    .rdata(g_rdata)
  );

  gdfs_ram #(.WIDTH(STK_W), .DEPTH(CELLS)) u_stack (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  // Input address and range check.
  assign in_store = (row < MAX_ROWS) && (col < MAX_COLS);
  assign in_addr  = cell_addr(ROW_W'(row), COL_W'(col));

  // Neighbor of the top cell in the direction under test, and its admission.
  assign cur_dir = cfg.order[{dir_i, 1'b0} +: 2];
  assign tr_s    = $signed(SW'(top_r));
  assign tc_s    = $signed(SW'(top_c));
  assign rows_s  = $signed(SW'(cfg.rows));
  assign cols_s  = $signed(SW'(cfg.cols));
  assign nr      = tr_s + step_row(cur_dir);
  assign nc      = tc_s + step_col(cur_dir);
  assign nb_ok   = (nr > ZERO_S) && (nc > ZERO_S) &&
                   (((nr < rows_s - ONE_S) && (nc < cols_s - ONE_S)) ||
                    ((nr == rows_s - TWO_S) && (nc == cols_s - ONE_S)));
  assign goal    = (tr_s == rows_s - TWO_S) && (tc_s == cols_s - ONE_S);

  assign in_stall = (state != S_IDLE);

  assign res.valid = (state == S_DONE);
  assign res.code  = res_cell;
  assign res.found = res_found;
  assign res.len   = res_len;

  // Sequencer: one memory access pattern per state.
  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    depth_next     = depth;
    top_r_next     = top_r;
    top_c_next     = top_c;
    nb_r_next      = nb_r;
    nb_c_next      = nb_c;
    dir_i_next     = dir_i;
    rd_ok_next     = rd_ok;
    res_cell_next  = res_cell;
    res_found_next = res_found;
    res_len_next   = res_len;
    g_we           = 1'b0;
    g_waddr        = cell_addr(top_r, top_c);
    g_wdata        = CODE_OPEN;
    g_raddr        = in_addr;
    s_we           = 1'b0;
    s_waddr        = depth[ADDR_W-1:0];
    s_wdata        = {nb_r, nb_c};
    s_raddr        = ADDR_W'(depth - DEPTH_W'(2));
    dead           = 1'b0;

    unique case (state)
      // Clearing pass over the grid after reset.
      S_CLEAR: begin
        g_we          = 1'b1;
        g_waddr       = clr_addr;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end

      // Take one item and start its action.
      S_IDLE: begin
        if (in_valid) begin
          res_cell_next  = CODE_OPEN;
          res_found_next = 1'b0;
          res_len_next   = '0;
          state_next     = S_DONE;
          unique case (action)
            ACT_WRITE: begin
              g_we    = in_store;
              g_waddr = in_addr;
              g_wdata = CODE_W'(cell_in);
            end
            ACT_SOLVE: begin
              depth_next = DEPTH_W'(1);
              s_we       = 1'b1;
              s_waddr    = '0;
              s_wdata    = {ROW_W'(1), COL_W'(0)};
              top_r_next = ROW_W'(1);
              top_c_next = '0;
              state_next = S_TOP;
            end
            ACT_READ: begin
              rd_ok_next = in_store;
              state_next = S_READ;
            end
            default: ;
          endcase
        end
      end

      // Grid read data is back.
      S_READ: begin
        res_cell_next = rd_ok ? g_rdata : CODE_OPEN;
        state_next    = S_DONE;
      end

      // Goal test on the top of the stack.
      S_TOP: begin
        if (goal) begin
          g_we           = 1'b1;
          g_wdata        = CODE_ARROW;
          res_found_next = 1'b1;
          res_len_next   = LEN_W'(depth);
          state_next     = S_DONE;
        end else begin
          dir_i_next = '0;
          state_next = S_PROBE;
        end
      end

      // Bounds check of one neighbor; read its code if it may be entered.
      S_PROBE: begin
        nb_r_next = nr[ROW_W-1:0];
        nb_c_next = nc[COL_W-1:0];
        g_raddr   = cell_addr(nr[ROW_W-1:0], nc[COL_W-1:0]);
        if (nb_ok) begin
          state_next = S_CHECK;
        end else if (dir_i == 2'd3) begin
          dead = 1'b1;
        end else begin
          dir_i_next = dir_i + 2'd1;
        end
      end

      // Open neighbor: mark the arrow, push it; else next direction or dead end.
      S_CHECK: begin
        if (g_rdata == CODE_OPEN) begin
          g_we    = 1'b1;
          g_wdata = CODE_ARROW + CODE_W'(cur_dir);
          if (depth < CELLS) begin
            s_we       = 1'b1;
            depth_next = depth + DEPTH_W'(1);
            top_r_next = nb_r;
            top_c_next = nb_c;
          end
          state_next = S_TOP;
        end else if (dir_i == 2'd3) begin
          dead = 1'b1;
        end else begin
          dir_i_next = dir_i + 2'd1;
          state_next = S_PROBE;
        end
      end

      // New top of the stack is back from memory.
      S_POP: begin
        top_r_next = s_rdata[COL_W +: ROW_W];
        top_c_next = s_rdata[COL_W-1:0];
        state_next = S_TOP;
      end

      // Result waits for the output register.
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
    endcase

    // Dead end: mark it, pop, and fetch the cell below if any is left.
    if (dead) begin
      g_we       = 1'b1;
      g_wdata    = CODE_DEAD;
      depth_next = depth - DEPTH_W'(1);
      if (depth == DEPTH_W'(1)) begin
        state_next = S_DONE;
      end else begin
        state_next = S_POP;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      depth    <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      depth    <= depth_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_r     <= top_r_next;
    top_c     <= top_c_next;
    nb_r      <= nb_r_next;
    nb_c      <= nb_c_next;
    dir_i     <= dir_i_next;
    rd_ok     <= rd_ok_next;
    res_cell  <= res_cell_next;
    res_found <= res_found_next;
    res_len   <= res_len_next;
  end

endmodule

/* rtl/grid_dfs_path_solver.sv */
// Top level of the grid path solver: register file, search core and output register.
// Depends on gdfs_pkg, gdfs_cfg, gdfs_core and gdfs_ram.
//
// Usage: the input channel (in_valid/in_stall) carries one action per transfer: write a
// cell (open or wall), run a solve from row 1 column 0 to the far-side goal, or read a
// cell code. Each action yields exactly one result transfer on out_valid/out_stall:
// cell_out for reads, found and path_cells for solves, zeros otherwise.
// Timing: a write or an unused action goes from acceptance straight to the result state;
// a read first waits for its grid RAM read. A solve steps from the goal test through
// a bounds check per neighbor, a grid RAM read per neighbor in bounds, and a push or
// a pop; the waits for grid RAM reads set the pace of a solve.
// One item is in work at a time; the next is accepted once the current result sits in
// the output register, so a stalled receiver leaves at most two finished results in the
// block: one in the output register and one waiting in the core, which stalls the input.
// Reset: rst clears the registers to 10 rows, 10 columns and order 228, then a
// clearing pass opens all 256 grid cells; in_stall is high meanwhile.
// Configuration writes are taken at any time but must only be issued while idle.
module grid_dfs_path_solver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gdfs_pkg::PADDR_W-1:0]  paddr,
  input  logic [gdfs_pkg::PDATA_W-1:0]  pwdata,
  output logic [gdfs_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gdfs_pkg::ACT_W-1:0]    action,
  input  logic [gdfs_pkg::IDX_W-1:0]    row,
  input  logic [gdfs_pkg::IDX_W-1:0]    col,
  input  logic                          cell_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gdfs_pkg::CODE_W-1:0]   cell_out,
  output logic                          found,
  output logic [gdfs_pkg::LEN_W-1:0]    path_cells
);
  import gdfs_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_take;

  gdfs_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  gdfs_core u_core (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action  (action),
    .row     (row),
    .col     (col),
    .cell_in (cell_in),
    .cfg     (cfg),
    .res_take(res_take),
    .res     (res)
  );

  // A result moves into the output register whenever that register is free or drains.
  assign res_take = res.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      cell_out   <= res.code;
      found      <= res.found;
      path_cells <= res.len;
    end
  end

endmodule

/* rtl/gdfs_checker.sv */
// Port-level checker for the grid path solver, bound to the top level.
// Depends on gdfs_pkg and the assertion macros in grid_dfs_path_solver_assert.svh.
`include "grid_dfs_path_solver_assert.svh"

module gdfs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [gdfs_pkg::CODE_W-1:0]  cell_out,
  input logic                         found,
  input logic [gdfs_pkg::LEN_W-1:0]   path_cells
);
  import gdfs_pkg::*;

  localparam logic [LEN_W-1:0] MIN_PATH = 2;

  // A stalled result holds until its transfer.
  `GDFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cell_out) && $stable(found) && $stable(path_cells), "stalled result changed")

  // Every accepted item keeps the block busy, so no two items are taken in a row.
  `GDFS_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken twice in a row")

  // A path length is only reported with a found goal.
  `GDFS_ASSERT_NOW(a_len_needs_found, out_valid && !found, path_cells == '0, "length without found goal")

  // A found path spans start and goal and carries no cell code.
  `GDFS_ASSERT_NOW(a_found_shape, out_valid && found, (path_cells >= MIN_PATH) && (cell_out == CODE_OPEN), "malformed solve result")

endmodule

bind grid_dfs_path_solver gdfs_checker u_gdfs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .cell_out  (cell_out),
  .found     (found),
  .path_cells(path_cells)
);

/* tb/tb_top.sv */
// Testbench for grid_dfs_path_solver: a short scripted run, then random maze loads, solves
// and read-backs, checked against fixed answers or a maze model kept inside the bench.
// Depends on gdfs_pkg and the solver RTL; needs no files or arguments.
module tb_top;
  import gdfs_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 600;
  localparam bit FIXED = 1'b1;
  localparam bit MODEL = 1'b0;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic             wall;
  } action_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              hit;
    logic [LEN_W-1:0]  len;
  } answer_t;

  typedef struct packed {
    action_t a;
    bit      fixed;
    answer_t ans;
  } script_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ACT_W-1:0]   action = ACT_WRITE;
  logic [IDX_W-1:0]   row = '0;
  logic [IDX_W-1:0]   col = '0;
  logic               cell_in = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CODE_W-1:0]  cell_out;
  logic               found;
  logic [LEN_W-1:0]   path_cells;

  grid_dfs_path_solver dut (.*);

  always #6 clk = ~clk;

  // Maze model: cell codes, the search trail and the register copies.
  logic [CODE_W-1:0]  maze_cells [CELLS];
  logic [ADDR_W-1:0]  trail [CELLS];
  int unsigned        trail_len;
  logic [CNT_W-1:0]   rows_reg = ROWS_RST;
  logic [CNT_W-1:0]   cols_reg = COLS_RST;
  logic [ORDER_W-1:0] order_reg = ORDER_RST;
  answer_t            answer_q [$];

  // Idle rates in percent, hold-off control and run statistics.
  int send_idle = 7;
  int recv_idle = 83;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int n_actions = 0;
  int n_solves = 0;
  int n_paths = 0;
  int n_answers = 0;
  int n_settings = 1;

  // Scripted opening under the reset setting (10 x 10, east-south-west-north).
  script_t script [22] = '{
    '{'{ACT_READ,   4'd0,  4'd0,  1'b0}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd15, 4'd15, 1'b0}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_WRITE,  4'd15, 4'd15, 1'b1}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd15, 4'd15, 1'b0}, FIXED, '{CODE_WALL, 1'b0, 9'd0}},
    '{'{ACT_WRITE,  4'd15, 4'd15, 1'b0}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd15, 4'd15, 1'b1}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_WRITE,  4'd0,  4'd15, 1'b1}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_WRITE,  4'd15, 4'd0,  1'b1}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_UNUSED, 4'd15, 4'd15, 1'b1}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_WRITE,  4'd1,  4'd0,  1'b1}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_WRITE,  4'd1,  4'd3,  1'b1}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_SOLVE,  4'd0,  4'd0,  1'b0}, MODEL, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd1,  4'd0,  1'b0}, FIXED, '{CODE_ARROW, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd8,  4'd9,  1'b0}, FIXED, '{CODE_ARROW, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd1,  4'd3,  1'b0}, FIXED, '{CODE_WALL, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd2,  4'd2,  1'b0}, MODEL, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_SOLVE,  4'd0,  4'd0,  1'b0}, MODEL, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd1,  4'd0,  1'b0}, MODEL, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd0,  4'd15, 1'b0}, FIXED, '{CODE_WALL, 1'b0, 9'd0}},
    '{'{ACT_UNUSED, 4'd0,  4'd0,  1'b0}, FIXED, '{CODE_OPEN, 1'b0, 9'd0}},
    '{'{ACT_READ,   4'd15, 4'd0,  1'b0}, FIXED, '{CODE_WALL, 1'b0, 9'd0}},
    '{'{ACT_SOLVE,  4'd15, 4'd15, 1'b1}, MODEL, '{CODE_OPEN, 1'b0, 9'd0}}
  };

  // Grid sizes outside the storage range are pulled back to the nearest legal size.
  function automatic int fit_size(input logic [CNT_W-1:0] v, input int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Only interior cells and the goal may be entered; row 0 and column 0 never.
  function automatic bit can_enter(input int r, input int c, input int rows, input int cols);
    if (r <= 0 || c <= 0) return 1'b0;
    if (r < rows - 1 && c < cols - 1) return 1'b1;
    return (r == rows - 2 && c == cols - 1);
  endfunction

  // Depth-first walk from row 1 column 0, marking arrows and dead ends as it goes.
  function automatic void walk_maze(output logic reached, output logic [LEN_W-1:0] depth);
    int rows, cols, r, c, nr, nc, k;
    logic [ADDR_W-1:0] top;
    logic [1:0] dir;
    bit moved;
    rows = fit_size(rows_reg, MAX_ROWS);
    cols = fit_size(cols_reg, MAX_COLS);
    reached = 1'b0;
    depth = '0;
    trail[0] = ADDR_W'(MAX_COLS);
    trail_len = 1;
    while (trail_len > 0) begin
      top = trail[trail_len - 1];
      r = top / MAX_COLS;
      c = top % MAX_COLS;
      if (r == rows - 2 && c == cols - 1) begin
        maze_cells[top] = CODE_ARROW;
        reached = 1'b1;
        depth = LEN_W'(trail_len);
        return;
      end
      moved = 1'b0;
      for (k = 0; k < 4 && !moved; k++) begin
        dir = order_reg[2*k +: 2];
        nr = r;
        nc = c;
        case (dir)
          DIR_EAST:  nc = c + 1;
          DIR_SOUTH: nr = r + 1;
          DIR_WEST:  nc = c - 1;
          DIR_NORTH: nr = r - 1;
        endcase
        if (can_enter(nr, nc, rows, cols)) begin
          if (maze_cells[nr * MAX_COLS + nc] == CODE_OPEN) begin
            maze_cells[top] = CODE_ARROW + CODE_W'(dir);
            if (trail_len < CELLS) begin
              trail[trail_len] = ADDR_W'(nr * MAX_COLS + nc);
              trail_len++;
            end
            moved = 1'b1;
          end
        end
      end
      if (!moved) begin
        trail_len--;
        maze_cells[top] = CODE_DEAD;
      end
    end
  endfunction

  // Applies one accepted action to the model and returns the result it must produce.
  function automatic answer_t run_action(input action_t a);
    answer_t ans;
    logic ok;
    logic [LEN_W-1:0] n;
    ans = '0;
    case (a.act)
      ACT_WRITE: maze_cells[{a.r, a.c}] = a.wall ? CODE_WALL : CODE_OPEN;
      ACT_SOLVE: begin
        walk_maze(ok, n);
        ans.hit = ok;
        ans.len = ok ? n : '0;
      end
      ACT_READ:  ans.code = maze_cells[{a.r, a.c}];
      default:   ans = '0;
    endcase
    return ans;
  endfunction

  function automatic action_t make_action(input logic [ACT_W-1:0] act, input int r,
                                          input int c, input bit wall);
    action_t a;
    a.act = act;
    a.r = IDX_W'(r);
    a.c = IDX_W'(c);
    a.wall = wall;
    return a;
  endfunction

  // Offers one action, holds it until the transfer, then records its expected result.
  task automatic offer(input action_t a, input bit fixed, input answer_t fixed_ans);
    answer_t ans;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a.act;
    row <= a.r;
    col <= a.c;
    cell_in <= a.wall;
    do @(posedge clk); while (in_stall);
    ans = run_action(a);
    answer_q.push_back(fixed ? fixed_ans : ans);
    n_actions++;
    if (a.act == ACT_SOLVE) begin
      n_solves++;
      if (ans.hit) n_paths++;
    end
  endtask

  task automatic offer_random();
    offer(make_action(ACT_W'($urandom_range(3)), $urandom_range(15), $urandom_range(15),
                      1'($urandom_range(1))), MODEL, '0);
  endtask

  // Stops offering and waits until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ROWS:  rows_reg = val[CNT_W-1:0];
      REG_COLS:  cols_reg = val[CNT_W-1:0];
      REG_ORDER: order_reg = val[ORDER_W-1:0];
      default:   ;
    endcase
  endtask

  // One maze round: reload the grid in use, solve, read cells back, maybe solve again.
  task automatic maze_round();
    int rows, cols, wall_pct, r, c, k;
    rows = fit_size(rows_reg, MAX_ROWS);
    cols = fit_size(cols_reg, MAX_COLS);
    wall_pct = $urandom_range(35);
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        if ($urandom_range(99) < 4) offer_random();
        offer(make_action(ACT_WRITE, r, c, $urandom_range(99) < wall_pct), MODEL, '0);
      end
    end
    offer(make_action(ACT_SOLVE, $urandom_range(15), $urandom_range(15),
                      1'($urandom_range(1))), MODEL, '0);
    for (k = $urandom_range(2, 8); k > 0; k--) begin
      offer(make_action(ACT_READ, $urandom_range(rows - 1), $urandom_range(cols - 1),
                        1'($urandom_range(1))), MODEL, '0);
    end
    // A repeat solve runs over the marks left by the first one.
    if ($urandom_range(3) == 0) begin
      offer(make_action(ACT_SOLVE, 0, 0, 1'b0), MODEL, '0);
      offer(make_action(ACT_READ, 1, 0, 1'b0), MODEL, '0);
    end
    if ($urandom_range(7) == 0) drain();
  endtask

  // Receiver side: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // Each result transfer is compared field by field with the oldest expectation.
  always @(posedge clk) begin : check_results
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      n_answers++;
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result cell_out %0d found %0d path_cells %0d",
                 $time, cell_out, found, path_cells);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (cell_out !== want.code) begin
          $display("%0t: cell_out expected %0d got %0d", $time, want.code, cell_out);
          errors++;
        end
        if (found !== want.hit) begin
          $display("%0t: found expected %0d got %0d", $time, want.hit, found);
          errors++;
        end
        if (path_cells !== want.len) begin
          $display("%0t: path_cells expected %0d got %0d", $time, want.len, path_cells);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, scripted part, then register settings with random rounds.
  initial begin
    int ph, nrows, ncols, nord, budget, first;
    foreach (maze_cells[i]) maze_cells[i] = CODE_OPEN;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) offer(script[i].a, script[i].fixed, script[i].ans);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin nrows = 5;  ncols = 6;  nord = 228;  budget = 100; end
        1: begin nrows = 0;  ncols = 31; nord = 0;    budget = 100; end
        2: begin nrows = 16; ncols = 0;  nord = 255;  budget = 100; end
        3: begin
          nrows = $urandom_range(3, 8);
          ncols = $urandom_range(3, 8);
          nord = $urandom_range(255);
          budget = 100;
        end
        4: begin nrows = 2;  ncols = 4;  nord = $urandom_range(255); budget = 90; end
        5: begin nrows = 31; ncols = 16; nord = 8'h1B; budget = 200; end
        6: begin
          nrows = $urandom_range(3, 10);
          ncols = $urandom_range(3, 10);
          nord = $urandom_range(255);
          budget = 100;
        end
        default: begin nrows = 10; ncols = 10; nord = 228; budget = 60; end
      endcase
      reg_write(REG_ROWS, PDATA_W'(nrows));
      reg_write(REG_COLS, PDATA_W'(ncols));
      reg_write(REG_ORDER, PDATA_W'(nord));
      n_settings++;

      // Sender idles lightly, receiver heavily; then the reverse; then neither.
      if (ph < 3) begin
        send_idle = 7;
        recv_idle <= 83;
      end else if (ph < 6) begin
        send_idle = 83;
        recv_idle <= 7;
      end else begin
        send_idle = 0;
        recv_idle <= 0;
      end
      if (ph == 6) hold_req <= 1'b1;

      first = n_actions;
      do maze_round(); while (n_actions - first < budget);
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Ran %0d actions (%0d solves, %0d reaching the goal) over %0d register settings.",
             n_actions, n_solves, n_paths, n_settings);
    $display("Checked %0d results under three idle mixes and one long output hold-off.",
             n_answers);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #12000000;
    $display("%0t: timeout with %0d results outstanding", $time, answer_q.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule
